@@ rtl/dec2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dec2d_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int VEL_W   = 32;             // velocity / position word
   localparam int MASS_W  = 16;             // Q8.8 mass
   localparam int DIFF_W  = 33;             // magnitude of a 32-bit difference
   localparam int PROD_W  = 65;             // |dv| * |d|
   localparam int DOT_W   = 66;             // |dot| and dist2
   localparam int MSUM_W  = 17;
   localparam int HALF_W  = 33;             // chunk width for split multiplies
   localparam int TPROD_W = 99;             // |dot| * |d|
   localparam int PART_W  = 49;             // 33 x 16 partial product
   localparam int MPART_W = 50;             // 33 x 17 partial product
   localparam int DEN_W   = 83;             // dist2 * M
   localparam int DEN2_W  = 84;             // 2 * dist2 * M
   localparam int NUM_W   = 118;
   localparam int QUOT_W  = 36;             // velocity change stays below 2^35
   localparam int SUM_W   = 38;

   localparam logic [1:0] OC_PASS    = 2'd0;
   localparam logic [1:0] OC_COLLIDE = 2'd1;
   localparam logic [1:0] OC_NOMASS  = 2'd2;

   typedef struct packed {
      logic        [MASS_W-1:0] first_mass;
      logic signed [VEL_W-1:0]  first_x;
      logic signed [VEL_W-1:0]  first_y;
      logic signed [VEL_W-1:0]  first_vx;
      logic signed [VEL_W-1:0]  first_vy;
      logic        [MASS_W-1:0] second_mass;
      logic signed [VEL_W-1:0]  second_x;
      logic signed [VEL_W-1:0]  second_y;
      logic signed [VEL_W-1:0]  second_vx;
      logic signed [VEL_W-1:0]  second_vy;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] first_vx_after;
      logic signed [VEL_W-1:0] first_vy_after;
      logic signed [VEL_W-1:0] second_vx_after;
      logic signed [VEL_W-1:0] second_vy_after;
      logic        [1:0]       outcome;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic        [MASS_W-1:0] m1;
      logic        [MASS_W-1:0] m2;
      logic signed [VEL_W-1:0]  v1x;
      logic signed [VEL_W-1:0]  v1y;
      logic signed [VEL_W-1:0]  v2x;
      logic signed [VEL_W-1:0]  v2y;
      logic        [DIFF_W-1:0] adx;
      logic        [DIFF_W-1:0] ady;
      logic                     x_neg;
      logic                     y_neg;
      logic                     sx;     // dvx and dx differ in sign
      logic                     sy;
      logic        [PROD_W-1:0] p1;
      logic        [PROD_W-1:0] p2;
   } entry_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] v1x;
      logic signed [VEL_W-1:0] v1y;
      logic signed [VEL_W-1:0] v2x;
      logic signed [VEL_W-1:0] v2y;
      logic                    x_neg;
      logic                    y_neg;
      logic        [1:0]       outcome;
   } side_type;

endpackage

`default_nettype wire

@@ rtl/disc_elastic_collision_2d.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Elastic collision of two discs in the plane, fixed point.
// Request channel: drive req_data and raise req_push; the request is taken on a
// clock edge where req_full is low. Response channel: while rsp_empty is low the
// oldest response sits on rsp_data; raise rsp_pop to take it.
// Each request gives exactly one response, in request order: the four new
// velocities (saturated Q16.16) and an outcome code (pass, collide, no mass).
// Throughput is one request per clock while the back pipeline is not frozen
// (see below). A request passes one front register, the request queue, five
// arithmetic stages and a 36-stage restoring divider (one quotient bit per
// stage) followed by the output register before rsp_empty goes low. While a
// response waits and rsp_pop is low, the back pipeline freezes as a whole; the
// request queue and front register keep taking requests until they fill, then
// req_full rises. Reset is synchronous and empties every stage and the queue;
// no clearing pass is needed, requests are taken from the first cycle after.
module disc_elastic_collision_2d #(
   parameter int QUEUE_DEPTH = dec2d_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire dec2d_pkg::req_type req_data,
   output logic                    req_full,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output dec2d_pkg::rsp_type      rsp_data
);

   logic                 q_push, q_full, q_pop, q_empty;
   dec2d_pkg::entry_type q_wdata, q_rdata;

   dec2d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   dec2d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   dec2d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/dec2d_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dec2d_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire dec2d_pkg::req_type   req_data,
   output logic                      req_full,
   output logic                      q_push,
   output dec2d_pkg::entry_type      q_data,
   input  wire logic                 q_full
);

   logic                          load;
   logic                          front_valid_ff, front_valid_in;
   dec2d_pkg::entry_type          front_ff, front_in;
   logic signed [dec2d_pkg::DIFF_W-1:0] dx, dy, dvx, dvy;
   logic [dec2d_pkg::DIFF_W-1:0]  advx, advy;

   assign req_full = front_valid_ff && q_full;
   assign load     = req_push && !req_full;
   assign q_push   = front_valid_ff && !q_full;
   assign q_data   = front_ff;

   always_comb begin
      dx  = {req_data.second_x[31], req_data.second_x} - {req_data.first_x[31], req_data.first_x};
      dy  = {req_data.second_y[31], req_data.second_y} - {req_data.first_y[31], req_data.first_y};
      dvx = {req_data.second_vx[31], req_data.second_vx}
            - {req_data.first_vx[31], req_data.first_vx};
      dvy = {req_data.second_vy[31], req_data.second_vy}
            - {req_data.first_vy[31], req_data.first_vy};
      advx = dvx[32] ? dec2d_pkg::DIFF_W'(-dvx) : dec2d_pkg::DIFF_W'(dvx);
      advy = dvy[32] ? dec2d_pkg::DIFF_W'(-dvy) : dec2d_pkg::DIFF_W'(dvy);

      front_in.m1    = req_data.first_mass;
      front_in.m2    = req_data.second_mass;
      front_in.v1x   = req_data.first_vx;
      front_in.v1y   = req_data.first_vy;
      front_in.v2x   = req_data.second_vx;
      front_in.v2y   = req_data.second_vy;
      front_in.adx   = dx[32] ? dec2d_pkg::DIFF_W'(-dx) : dec2d_pkg::DIFF_W'(dx);
      front_in.ady   = dy[32] ? dec2d_pkg::DIFF_W'(-dy) : dec2d_pkg::DIFF_W'(dy);
      front_in.x_neg = dx[32];
      front_in.y_neg = dy[32];
      front_in.sx    = dvx[32] != dx[32];
      front_in.sy    = dvy[32] != dy[32];
      front_in.p1    = dec2d_pkg::PROD_W'(dec2d_pkg::PROD_W'(advx)
                                          * dec2d_pkg::PROD_W'(front_in.adx));
      front_in.p2    = dec2d_pkg::PROD_W'(dec2d_pkg::PROD_W'(advy)
                                          * dec2d_pkg::PROD_W'(front_in.ady));
   end

   assign front_valid_in = load || (front_valid_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (load) begin
         front_ff <= front_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dec2d_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dec2d_queue #(
   parameter int DEPTH = dec2d_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire dec2d_pkg::entry_type push_data,
   output logic                      full,
   input  wire logic                 pop,
   output dec2d_pkg::entry_type      pop_data,
   output logic                      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec2d_pkg::entry_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(do_push && !do_pop) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty with pointers apart");

endmodule

`default_nettype wire

@@ rtl/dec2d_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage.
module dec2d_div (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [dec2d_pkg::NUM_W-1:0]   num,
   input  wire logic [dec2d_pkg::DEN2_W-1:0]  den,
   output logic      [dec2d_pkg::QUOT_W-1:0]  quot
);

   localparam int QW = dec2d_pkg::QUOT_W;
   localparam int DW = dec2d_pkg::DEN2_W;
   localparam int NW = dec2d_pkg::NUM_W;

   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] rem_in  [QW];
   logic [QW-1:0] bits_ff [QW];
   logic [QW-1:0] bits_in [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [DW-1:0] src_rem [QW];
   logic [QW-1:0] src_bits[QW];
   logic [DW-1:0] src_den [QW];
   logic [QW-1:0] src_quo [QW];

   always_comb begin
      logic [DW:0] trial;
      logic        qbit;
      src_rem[0]  = DW'(num[NW-1:QW]);
      src_bits[0] = num[QW-1:0];
      src_den[0]  = den;
      src_quo[0]  = '0;
      for (int j = 1; j < QW; j++) begin
         src_rem[j]  = rem_ff[j-1];
         src_bits[j] = bits_ff[j-1];
         src_den[j]  = den_ff[j-1];
         src_quo[j]  = quo_ff[j-1];
      end
      for (int j = 0; j < QW; j++) begin
         trial = {src_rem[j], src_bits[j][QW-1]};
         qbit  = trial >= {1'b0, src_den[j]};
         rem_in[j]  = qbit ? DW'(trial - {1'b0, src_den[j]}) : DW'(trial);
         bits_in[j] = src_bits[j] << 1;
         quo_in[j]  = {src_quo[j][QW-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QW; j++) begin
            rem_ff[j]  <= rem_in[j];
            bits_ff[j] <= bits_in[j];
            den_ff[j]  <= src_den[j];
            quo_ff[j]  <= quo_in[j];
         end
      end
   end

   assign quot = quo_ff[QW-1];

endmodule

`default_nettype wire

@@ rtl/dec2d_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dec2d_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire dec2d_pkg::entry_type q_data,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output dec2d_pkg::rsp_type        rsp_data
);

   localparam int QW = dec2d_pkg::QUOT_W;
   localparam int HW = dec2d_pkg::HALF_W;

   function automatic logic signed [dec2d_pkg::VEL_W-1:0] sat_add(
      input logic signed [dec2d_pkg::VEL_W-1:0] v,
      input logic [QW-1:0] c,
      input logic sub);
      logic signed [dec2d_pkg::SUM_W-1:0] cs, sum;
      cs  = signed'({2'b00, c});
      sum = sub ? dec2d_pkg::SUM_W'(v) - cs : dec2d_pkg::SUM_W'(v) + cs;
      if (sum > dec2d_pkg::SUM_W'(signed'(32'sh7fffffff))) begin
         sat_add = 32'sh7fffffff;
      end else if (sum < dec2d_pkg::SUM_W'(signed'(32'sh80000000))) begin
         sat_add = 32'sh80000000;
      end else begin
         sat_add = sum[dec2d_pkg::VEL_W-1:0];
      end
   endfunction

   logic adv;

   // stage 0: dot sign and magnitude, squares
   logic                                 s0_valid_ff;
   dec2d_pkg::side_type                  s0_side_ff, s0_side_in;
   logic [dec2d_pkg::DOT_W-1:0]          s0_dot_ff, s0_dot_in;
   logic [dec2d_pkg::MSUM_W-1:0]         s0_msum_ff, s0_msum_in;
   logic [dec2d_pkg::MASS_W-1:0]         s0_m1_ff, s0_m2_ff;
   logic [dec2d_pkg::DIFF_W-1:0]         s0_adx_ff, s0_ady_ff;
   logic [dec2d_pkg::DOT_W-1:0]          s0_sqx_ff, s0_sqy_ff;
   // stage 1
   logic                                 s1_valid_ff;
   dec2d_pkg::side_type                  s1_side_ff;
   logic [dec2d_pkg::MSUM_W-1:0]         s1_msum_ff;
   logic [dec2d_pkg::MASS_W-1:0]         s1_m1_ff, s1_m2_ff;
   logic [dec2d_pkg::DOT_W-1:0]          s1_dist2_ff;
   logic [dec2d_pkg::DOT_W-1:0]          s1_txl_ff, s1_txh_ff, s1_tyl_ff, s1_tyh_ff;
   // stage 2
   logic                                 s2_valid_ff;
   dec2d_pkg::side_type                  s2_side_ff;
   logic [dec2d_pkg::MASS_W-1:0]         s2_m1_ff, s2_m2_ff;
   logic [dec2d_pkg::TPROD_W-1:0]        s2_tx_ff, s2_ty_ff;
   logic [dec2d_pkg::MPART_W-1:0]        s2_dl_ff, s2_dh_ff;
   // stage 3
   logic                                 s3_valid_ff;
   dec2d_pkg::side_type                  s3_side_ff;
   logic [dec2d_pkg::DEN_W-1:0]          s3_den_ff;
   logic [dec2d_pkg::PART_W-1:0]         s3_pp_ff [4][3];
   logic [dec2d_pkg::PART_W-1:0]         s3_pp_in [4][3];
   // stage 4
   logic                                 s4_valid_ff;
   dec2d_pkg::side_type                  s4_side_ff;
   logic [dec2d_pkg::NUM_W-1:0]          s4_num_ff [4];
   logic [dec2d_pkg::NUM_W-1:0]          s4_num_in [4];
   logic [dec2d_pkg::DEN2_W-1:0]         s4_den2_ff;
   // divider alignment
   logic                                 dly_valid_ff [QW];
   dec2d_pkg::side_type                  dly_side_ff  [QW];
   logic [QW-1:0]                        quot [4];
   // output
   logic                                 out_valid_ff;
   dec2d_pkg::rsp_type                   out_ff, out_in;

   assign adv       = !out_valid_ff || rsp_pop;
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic n1, n2, neg;
      n1 = (q_data.p1 != '0) && q_data.sx;
      n2 = (q_data.p2 != '0) && q_data.sy;
      if (n1 == n2) begin
         s0_dot_in = dec2d_pkg::DOT_W'(q_data.p1) + dec2d_pkg::DOT_W'(q_data.p2);
         neg       = n1;
      end else if (q_data.p1 >= q_data.p2) begin
         s0_dot_in = dec2d_pkg::DOT_W'(q_data.p1 - q_data.p2);
         neg       = n1 && (q_data.p1 != q_data.p2);
      end else begin
         s0_dot_in = dec2d_pkg::DOT_W'(q_data.p2 - q_data.p1);
         neg       = n2;
      end
      s0_msum_in = dec2d_pkg::MSUM_W'(q_data.m1) + dec2d_pkg::MSUM_W'(q_data.m2);
      s0_side_in.v1x   = q_data.v1x;
      s0_side_in.v1y   = q_data.v1y;
      s0_side_in.v2x   = q_data.v2x;
      s0_side_in.v2y   = q_data.v2y;
      s0_side_in.x_neg = q_data.x_neg;
      s0_side_in.y_neg = q_data.y_neg;
      if (!neg) begin
         s0_side_in.outcome = dec2d_pkg::OC_PASS;
      end else if (s0_msum_in == '0) begin
         s0_side_in.outcome = dec2d_pkg::OC_NOMASS;
      end else begin
         s0_side_in.outcome = dec2d_pkg::OC_COLLIDE;
      end
   end

   // partial products of |dot|*|d|*m, order: c1x, c1y, c2x, c2y
   always_comb begin
      logic [dec2d_pkg::TPROD_W-1:0] t;
      logic [dec2d_pkg::MASS_W-1:0]  m;
      for (int k = 0; k < 4; k++) begin
         t = (k == 0 || k == 2) ? s2_tx_ff : s2_ty_ff;
         m = (k < 2) ? s2_m2_ff : s2_m1_ff;
         for (int c = 0; c < 3; c++) begin
            s3_pp_in[k][c] = dec2d_pkg::PART_W'(dec2d_pkg::PART_W'(t[c*HW +: HW])
                                                * dec2d_pkg::PART_W'(m));
         end
      end
   end

   always_comb begin
      logic [dec2d_pkg::NUM_W-1:0] sum;
      for (int k = 0; k < 4; k++) begin
         sum = (dec2d_pkg::NUM_W'(s3_pp_ff[k][2]) << (2 * HW))
               + (dec2d_pkg::NUM_W'(s3_pp_ff[k][1]) << HW)
               + dec2d_pkg::NUM_W'(s3_pp_ff[k][0]);
         // half the divisor added in for round-half-up
         s4_num_in[k] = (sum << 2) + dec2d_pkg::NUM_W'(s3_den_ff);
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_div
      dec2d_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (s4_num_ff[k]),
         .den   (s4_den2_ff),
         .quot  (quot[k])
      );
   end

   always_comb begin
      dec2d_pkg::side_type sd;
      logic                col;
      sd  = dly_side_ff[QW-1];
      col = sd.outcome == dec2d_pkg::OC_COLLIDE;
      out_in.first_vx_after  = col ? sat_add(sd.v1x, quot[0], !sd.x_neg) : sd.v1x;
      out_in.first_vy_after  = col ? sat_add(sd.v1y, quot[1], !sd.y_neg) : sd.v1y;
      out_in.second_vx_after = col ? sat_add(sd.v2x, quot[2], sd.x_neg) : sd.v2x;
      out_in.second_vy_after = col ? sat_add(sd.v2y, quot[3], sd.y_neg) : sd.v2y;
      out_in.outcome         = sd.outcome;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < QW; j++) begin
            dly_valid_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s0_valid_ff     <= !q_empty;
         s1_valid_ff     <= s0_valid_ff;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         dly_valid_ff[0] <= s4_valid_ff;
         for (int j = 1; j < QW; j++) begin
            dly_valid_ff[j] <= dly_valid_ff[j-1];
         end
         out_valid_ff <= dly_valid_ff[QW-1];
      end

      if (adv) begin
         s0_side_ff <= s0_side_in;
         s0_dot_ff  <= s0_dot_in;
         s0_msum_ff <= s0_msum_in;
         s0_m1_ff   <= q_data.m1;
         s0_m2_ff   <= q_data.m2;
         s0_adx_ff  <= q_data.adx;
         s0_ady_ff  <= q_data.ady;
         s0_sqx_ff  <= dec2d_pkg::DOT_W'(dec2d_pkg::DOT_W'(q_data.adx)
                                         * dec2d_pkg::DOT_W'(q_data.adx));
         s0_sqy_ff  <= dec2d_pkg::DOT_W'(dec2d_pkg::DOT_W'(q_data.ady)
                                         * dec2d_pkg::DOT_W'(q_data.ady));

         s1_side_ff  <= s0_side_ff;
         s1_msum_ff  <= s0_msum_ff;
         s1_m1_ff    <= s0_m1_ff;
         s1_m2_ff    <= s0_m2_ff;
         s1_dist2_ff <= s0_sqx_ff + s0_sqy_ff;
         s1_txl_ff   <= dec2d_pkg::DOT_W'(dec2d_pkg::DOT_W'(s0_dot_ff[HW-1:0])
                                          * dec2d_pkg::DOT_W'(s0_adx_ff));
         s1_txh_ff   <= dec2d_pkg::DOT_W'(dec2d_pkg::DOT_W'(s0_dot_ff[2*HW-1:HW])
                                          * dec2d_pkg::DOT_W'(s0_adx_ff));
         s1_tyl_ff   <= dec2d_pkg::DOT_W'(dec2d_pkg::DOT_W'(s0_dot_ff[HW-1:0])
                                          * dec2d_pkg::DOT_W'(s0_ady_ff));
         s1_tyh_ff   <= dec2d_pkg::DOT_W'(dec2d_pkg::DOT_W'(s0_dot_ff[2*HW-1:HW])
                                          * dec2d_pkg::DOT_W'(s0_ady_ff));

         s2_side_ff <= s1_side_ff;
         s2_m1_ff   <= s1_m1_ff;
         s2_m2_ff   <= s1_m2_ff;
         s2_tx_ff   <= (dec2d_pkg::TPROD_W'(s1_txh_ff) << HW) + dec2d_pkg::TPROD_W'(s1_txl_ff);
         s2_ty_ff   <= (dec2d_pkg::TPROD_W'(s1_tyh_ff) << HW) + dec2d_pkg::TPROD_W'(s1_tyl_ff);
         s2_dl_ff   <= dec2d_pkg::MPART_W'(dec2d_pkg::MPART_W'(s1_dist2_ff[HW-1:0])
                                           * dec2d_pkg::MPART_W'(s1_msum_ff));
         s2_dh_ff   <= dec2d_pkg::MPART_W'(dec2d_pkg::MPART_W'(s1_dist2_ff[2*HW-1:HW])
                                           * dec2d_pkg::MPART_W'(s1_msum_ff));

         s3_side_ff <= s2_side_ff;
         s3_den_ff  <= (dec2d_pkg::DEN_W'(s2_dh_ff) << HW) + dec2d_pkg::DEN_W'(s2_dl_ff);
         s3_pp_ff   <= s3_pp_in;

         s4_side_ff <= s3_side_ff;
         s4_num_ff  <= s4_num_in;
         s4_den2_ff <= {s3_den_ff, 1'b0};

         dly_side_ff[0] <= s4_side_ff;
         for (int j = 1; j < QW; j++) begin
            dly_side_ff[j] <= dly_side_ff[j-1];
         end
         out_ff <= out_in;
      end
   end

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> out_valid_ff)
      else $error("result lost while receiver stalled");

   a_collide_mass: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && (s0_side_ff.outcome == dec2d_pkg::OC_COLLIDE) |-> s0_msum_ff != '0)
      else $error("collision classified with zero mass sum");

endmodule

`default_nettype wire
